### hw/rtl/slid_pkg.sv
// slid_pkg: codes, types and controller/datapath interface structs
// for the sorted list insert/delete block; no dependencies
package slid_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // requested action
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // datapath store operation
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    op_e     op;
    logic    emit;
    status_e status;
    logic    last;
    logic    show;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic found;
    logic rd_last;
  } dp_stat_t;

endpackage

### hw/rtl/sorted_list_insert_delete.sv
// sorted_list_insert_delete: top level of the sorted store
// depends on slid_pkg, slid_ctrl and slid_dp
//
//   channel   handshake          fields
//   command   start_i / busy_o   action_i, value_i
//   result    done_o (strobe)    status_o, entry_value_o, last_o, entry_count_o
//
// for insert, delete, other actions and a readout of an empty store, the
// accept cycle captures the parallel compare of all cells, the next cycle
// shifts the row for a successful insert or delete; a readout of a non-empty
// store emits one entry a cycle as the occupied cells rotate past cell 0
// each result shows in the cycle after its work cycle; reset clears the entry
// and readout counts, the state and done_o; cells stay undefined until written
// results cannot be stalled: done_o is high for exactly one cycle per result
module sorted_list_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] entry_value_o,
  output logic               last_o,
  output logic [4:0]         entry_count_o
);
  import slid_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing
  slid_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .stat_i   (stat),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  // cells and result registers
  slid_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (action_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .last_o        (last_o),
    .entry_count_o (entry_count_o)
  );

`ifndef SYNTH
  // an accepted word always raises busy_o in the following cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accepted word");

  // going idle always coincides with the final result of the word
  a_idle_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o && last_o)
    else $error("block went idle without a final result");

  // refused or failed operations give a single result
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> last_o && (entry_value_o == '0))
    else $error("error result not single or carries an entry");

  // no result while an idle block has seen no word
  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !start_i |=> !busy_o && (done_o == $past(busy_o)))
    else $error("result strobe without pending work");
`endif

endmodule

### hw/rtl/slid_ctrl.sv
// slid_ctrl: sequencing state machine for the sorted list block
// depends on slid_pkg (command and status structs, codes)
module slid_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         action_i,
  input  slid_pkg::dp_stat_t stat_i,
  output logic               busy_o,
  output slid_pkg::ctl_cmd_t cmd_o
);
  import slid_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state_q, state_d;
  action_e    act_q, act_d;
  logic       accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && (state_q == S_IDLE);

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    cmd_o      = '0;
    cmd_o.op   = OP_HOLD;
    cmd_o.status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          act_d      = action_e'(action_i);
          if (action_e'(action_i) == ACT_READ && !stat_i.empty) begin
            state_d = S_READ;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = 1'b1;
        state_d    = S_IDLE;
        unique case (act_q)
          ACT_INSERT: begin
            if (stat_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.op = OP_INSERT;
            end
          end
          ACT_DELETE: begin
            if (stat_i.empty) begin
              cmd_o.status = ST_EMPTY;
            end else if (!stat_i.found) begin
              cmd_o.status = ST_NOT_FOUND;
            end else begin
              cmd_o.op = OP_DELETE;
            end
          end
          // readout only lands here on an empty store
          ACT_READ: cmd_o.status = ST_EMPTY;
          ACT_NONE: cmd_o.status = ST_OK;
        endcase
      end
      S_READ: begin
        cmd_o.op   = OP_ROTATE;
        cmd_o.emit = 1'b1;
        cmd_o.show = 1'b1;
        cmd_o.last = stat_i.rd_last;
        if (stat_i.rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_NONE;
    end else begin
      state_q <= state_d;
      if (accept) begin
        act_q <= act_d;
      end
    end
  end

endmodule

### hw/rtl/slid_dp.sv
// slid_dp: row of sorted cells with parallel compare, shift and rotate,
// entry counter, readout counter and result registers; depends on slid_pkg
module slid_dp #(
  parameter int DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    action_i,
  input  logic signed [31:0]            value_i,
  input  slid_pkg::ctl_cmd_t            cmd_i,
  output slid_pkg::dp_stat_t            stat_o,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic signed [31:0]            entry_value_o,
  output logic                          last_o,
  output logic [4:0]                    entry_count_o
);
  import slid_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic signed [VALUE_W-1:0] entries_q [DEPTH];
  logic signed [VALUE_W-1:0] entry_d   [DEPTH];
  logic signed [VALUE_W-1:0] value_q;
  logic [DEPTH-1:0]          gt, eq, pre_eq, shift_q;
  logic                      found_q;
  logic [CW-1:0]             count_q, count_d;
  logic [IW-1:0]             rd_idx_q;

  logic                      done_q, last_q;
  status_e                   status_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [COUNT_W-1:0]        out_count_q;

  // per-cell compare against the incoming word and per-cell next value
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CW-1:0] IDX  = CW'(g);
    localparam logic [CW-1:0] IDX1 = CW'(g + 1);
    logic                      valid;
    logic                      prev_shift;
    logic signed [VALUE_W-1:0] prev_val, next_val;

    assign valid     = (IDX < count_q);
    // cells past the end count as greater, so the insert point is found
    assign gt[g]     = !valid || (entries_q[g] > value_i);
    assign eq[g]     = valid && (entries_q[g] == value_i);
    assign pre_eq[g] = |eq[g:0];

    if (g == 0) begin : g_first
      assign prev_shift = 1'b0;
      assign prev_val   = value_q;
    end else begin : g_mid
      assign prev_shift = shift_q[g-1];
      assign prev_val   = entries_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign next_val = entries_q[g];
    end else begin : g_body
      assign next_val = entries_q[g+1];
    end

    always_comb begin
      entry_d[g] = entries_q[g];
      unique case (cmd_i.op)
        OP_INSERT: begin
          if (shift_q[g]) begin
            entry_d[g] = prev_shift ? prev_val : value_q;
          end
        end
        OP_DELETE: begin
          if (shift_q[g]) begin
            entry_d[g] = next_val;
          end
        end
        // rotate the occupied part left by one
        OP_ROTATE: begin
          if (IDX1 < count_q) begin
            entry_d[g] = next_val;
          end else if (IDX1 == count_q) begin
            entry_d[g] = entries_q[0];
          end
        end
        OP_HOLD: entry_d[g] = entries_q[g];
      endcase
    end
  end

  // cell storage, undefined until written
  always_ff @(posedge clk_i) begin
    entries_q <= entry_d;
  end

  // operand and compare flags captured with the command word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
      shift_q <= (action_e'(action_i) == ACT_DELETE) ? pre_eq : gt;
      found_q <= |eq;
    end
  end

  // entry count
  always_comb begin
    count_d = count_q;
    unique case (cmd_i.op)
      OP_INSERT: count_d = count_q + CW'(1);
      OP_DELETE: count_d = count_q - CW'(1);
      OP_ROTATE: count_d = count_q;
      OP_HOLD:   count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        rd_idx_q <= '0;
      end else if (cmd_i.op == OP_ROTATE) begin
        rd_idx_q <= rd_idx_q + IW'(1);
      end
    end
  end

  // status back to the controller
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.full    = (count_q == CW'(DEPTH));
  assign stat_o.found   = found_q;
  assign stat_o.rd_last = (CW'(rd_idx_q) == count_q - CW'(1));

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q    <= cmd_i.status;
      last_q      <= cmd_i.last;
      out_value_q <= cmd_i.show ? entries_q[0] : '0;
      out_count_q <= COUNT_W'(count_d);
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_value_o = out_value_q;
  assign last_o        = last_q;
  assign entry_count_o = out_count_q;

endmodule
